// File: hw/rtl/nts_pkg.sv
// Shared types and constants for the non-preemptive tick scheduler.
// No dependencies.
package nts_pkg;
  localparam int MAX_PROCS = 16;
  localparam int TIME_BITS = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam logic [3:0] CFG_POLICY = 4'd0;
  localparam logic [3:0] CFG_COUNT  = 4'd1;
  localparam logic POLICY_FCFS = 1'b0;
  localparam logic POLICY_SPN  = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // write table entry from request
    logic start;     // latch time, clear scan state
    logic arr_step;  // examine one slot for arrival
    logic pick_step; // examine one queue entry for dispatch
    logic dispatch;  // take chosen entry
    logic rd_issue;  // read remaining/arrival of running slot
    logic finish;    // update remaining, build result
  } nts_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic arr_last;
    logic pick_last;
    logic need_pick;
  } nts_stat_t;
endpackage

// File: hw/rtl/nts_if.sv
// Valid/ready channel interface with a parameterized payload type.
// Depends on nothing.
interface nts_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/nts_ctrl.sv
// Controller state machine for the tick scheduler.
// Depends on nts_pkg.
module nts_ctrl import nts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_ready,
  input  logic      out_busy,
  output logic      out_load,
  input  nts_stat_t stat,
  output nts_cmd_t  cmd
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ARR  = 6'b000010,
    S_PICK = 6'b000100,
    S_RD   = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_next = S_ARR;
          end
        end
      end
      S_ARR: begin
        cmd.arr_step = 1'b1;
        if (stat.arr_last) state_next = S_PICK;
      end
      S_PICK: begin
        if (!stat.need_pick) begin
          state_next = S_RD;
        end else if (stat.pick_last) begin
          cmd.dispatch = 1'b1;
          state_next = S_RD;
        end else begin
          cmd.pick_step = 1'b1;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> $past(state) == S_FIN || $past(state) == S_OUT)
    else $error("result without finish step");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(cmd.arr_step || cmd.finish))
    else $error("request taken while busy");
`endif
endmodule

// File: hw/rtl/nts_dp.sv
// Datapath for the tick scheduler: process tables, ready queue, time counter.
// Depends on nts_pkg.
module nts_dp import nts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  nts_cmd_t    cmd,
  output nts_stat_t   stat,
  input  logic        cfg_policy,
  input  logic [4:0]  cfg_count,
  input  logic [3:0]  ld_index,
  input  logic [15:0] ld_arrival,
  input  logic [15:0] ld_service,
  output logic [15:0] r_tick_time,
  output logic        r_running_valid,
  output logic [3:0]  r_running_slot,
  output logic [15:0] r_waiting_mask,
  output logic        r_done_valid,
  output logic [15:0] r_finish_time,
  output logic [15:0] r_turnaround,
  output logic [15:0] r_done_service
);
  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  logic [TIME_BITS-1:0] arr_tab [MAX_PROCS];
  logic [15:0]          svc_tab [MAX_PROCS];
  logic [15:0]          rem_tab [MAX_PROCS];
  logic [IW-1:0]        fifo    [MAX_PROCS];
  logic [IW-1:0]        head, tail;
  logic [CW-1:0]        fill;
  logic [MAX_PROCS-1:0] ready_bits;
  logic                 cpu_busy;
  logic [IW-1:0]        cur;
  logic [TIME_BITS-1:0] now, time_cnt;
  logic [CW-1:0]        scan;     // arrival slot / queue offset
  logic [CW-1:0]        limit;
  logic [CW-1:0]        pick;
  logic [15:0]          pick_svc;
  logic [15:0]          rem_q;
  logic [TIME_BITS-1:0] arr_q;

  logic [IW-1:0] scan_slot, qslot, pslot;
  logic          arrives;
  logic [15:0]   rem_dec;
  logic [TIME_BITS-1:0] diff;
  logic [TIME_BITS:0]   turn;

  assign limit = (cfg_count > CW'(MAX_PROCS)) ? CW'(MAX_PROCS) : cfg_count;
  assign scan_slot = scan[IW-1:0];
  assign arrives = (scan < limit) && arr_tab[scan_slot] == now && !ready_bits[scan_slot]
                   && !(cpu_busy && cur == scan_slot) && fill < CW'(MAX_PROCS);
  assign qslot = fifo[IW'(head + scan[IW-1:0])];
  assign pslot = fifo[IW'(head + pick[IW-1:0])];
  assign stat.arr_last  = scan >= limit - 1'b1 || limit == '0;
  assign stat.need_pick = !cpu_busy && fill != '0;
  assign stat.pick_last = cfg_policy == POLICY_FCFS || scan >= fill;
  assign rem_dec = (rem_q != '0) ? rem_q - 16'd1 : 16'd0;
  assign diff = now - arr_q;
  assign turn = {1'b0, diff} + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load && {1'b0, ld_index} < 5'(MAX_PROCS)) begin
      arr_tab[IW'(ld_index)] <= TIME_BITS'(ld_arrival);
      svc_tab[IW'(ld_index)] <= ld_service;
      rem_tab[IW'(ld_index)] <= ld_service;
    end
    if (cmd.arr_step && arrives) begin
      rem_tab[scan_slot] <= svc_tab[scan_slot];
      fifo[tail] <= scan_slot;
    end
    if (cmd.pick_step && (scan == '0 || svc_tab[qslot] < pick_svc)) begin
      pick_svc <= svc_tab[qslot];
    end
    // remove picked entry; entries ahead of it shift back one place
    if (cmd.dispatch) begin
      for (int k = 1; k < MAX_PROCS; k++)
        if (CW'(k) <= pick) fifo[IW'(head + IW'(k))] <= fifo[IW'(head + IW'(k - 1))];
    end
    if (cmd.rd_issue) begin
      rem_q <= rem_tab[cur];
      arr_q <= arr_tab[cur];
    end
    if (cmd.finish && cpu_busy) rem_tab[cur] <= rem_dec;
    if (cmd.start) now <= time_cnt;
    if (cmd.finish) begin
      r_tick_time     <= 16'(now);
      r_running_valid <= cpu_busy;
      r_running_slot  <= cpu_busy ? 4'(cur) : 4'd0;
      r_waiting_mask  <= 16'(ready_bits);
      r_done_valid    <= cpu_busy && rem_dec == '0;
      r_finish_time   <= (cpu_busy && rem_dec == '0) ? 16'(now) : 16'd0;
      r_turnaround    <= (cpu_busy && rem_dec == '0) ?
                         16'(turn[TIME_BITS] ? TMAX : turn[TIME_BITS-1:0]) : 16'd0;
      r_done_service  <= (cpu_busy && rem_dec == '0) ? svc_tab[cur] : 16'd0;
    end
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
      ready_bits <= '0;
      cpu_busy <= 1'b0;
      cur <= '0;
      time_cnt <= '0;
      scan <= '0;
      pick <= '0;
    end else begin
      if (cmd.start) begin
        scan <= '0;
        pick <= '0;
      end else if (cmd.arr_step) begin
        scan <= stat.arr_last ? '0 : scan + 1'b1;
      end else if (cmd.pick_step) begin
        scan <= scan + 1'b1;
        if (scan != '0 && svc_tab[qslot] < pick_svc) pick <= scan;
      end
      if (cmd.arr_step && arrives) begin
        tail <= tail + 1'b1;
        fill <= fill + 1'b1;
        ready_bits[scan_slot] <= 1'b1;
      end
      if (cmd.dispatch) begin
        cur <= pslot;
        head <= head + 1'b1;
        fill <= fill - 1'b1;
        ready_bits[pslot] <= 1'b0;
        cpu_busy <= 1'b1;
      end
      if (cmd.finish) begin
        time_cnt <= now + 1'b1;
        if (cpu_busy && rem_dec == '0) cpu_busy <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_fill: assert property (@(posedge clk) disable iff (rst) fill <= CW'(MAX_PROCS))
    else $error("queue overfilled");
  a_count: assert property (@(posedge clk) disable iff (rst)
    $countones(ready_bits) == int'(fill))
    else $error("ready bits disagree with queue fill");
  a_disp: assert property (@(posedge clk) disable iff (rst)
    cmd.dispatch |=> cpu_busy)
    else $error("dispatch did not occupy cpu");
`endif
endmodule

// File: hw/rtl/nonpreemptive_tick_scheduler_unit.sv
// Non-preemptive FCFS / SPN tick scheduler, one tick or load per request.
// Load: accepted in idle. Tick: accept, min(process_count, 16) arrival steps
// (at least 1), one queue step (fill+1 in SPN when dispatching), then read,
// finish and output steps; one request in flight.
// The result register lets the next request enter while a result waits.
// Synchronous active-high reset clears queue, busy flag, time and config.
module nonpreemptive_tick_scheduler_unit import nts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  nts_if.sink         in_ch,
  nts_if.source       out_ch,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  nts_cmd_t  cmd;
  nts_stat_t stat;
  logic       policy;
  logic [4:0] count;
  logic       out_load;
  logic [15:0] tt, fin, trn, dsv, wm;
  logic        rv, dv;
  logic [3:0]  rs;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POLICY_FCFS;
      count <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_POLICY) policy <= cfg_data[0];
      else if (cfg_index == CFG_COUNT) count <= cfg_data;
    end
  end

  nts_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_op(in_ch.data.op), .in_ready(in_ch.ready),
    .out_busy(out_ch.valid && !out_ch.ready), .out_load, .stat, .cmd
  );

  nts_dp u_dp (
    .clk, .rst, .cmd, .stat, .cfg_policy(policy), .cfg_count(count),
    .ld_index(in_ch.data.proc_index), .ld_arrival(in_ch.data.arrival_time),
    .ld_service(in_ch.data.service_time),
    .r_tick_time(tt), .r_running_valid(rv), .r_running_slot(rs),
    .r_waiting_mask(wm), .r_done_valid(dv), .r_finish_time(fin),
    .r_turnaround(trn), .r_done_service(dsv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
    if (out_load) begin
      out_ch.data.tick_time     <= tt;
      out_ch.data.running_valid <= rv;
      out_ch.data.running_slot  <= rs;
      out_ch.data.waiting_mask  <= wm;
      out_ch.data.done_valid    <= dv;
      out_ch.data.finish_time   <= fin;
      out_ch.data.turnaround    <= trn;
      out_ch.data.done_service  <= dsv;
    end
  end
endmodule

// File: tb/sv/tb_nonpreemptive_tick_scheduler_unit.sv
`timescale 1ns / 1ps
// Self-checking regression for the FCFS / SPN tick scheduler unit.
// Depends on nts_pkg, nts_if and the nonpreemptive_tick_scheduler_unit RTL.
module tb_nonpreemptive_tick_scheduler_unit;
  import nts_pkg::*;

  typedef struct packed {
    logic        op;
    logic [3:0]  proc_index;
    logic [15:0] arrival_time;
    logic [15:0] service_time;
  } sched_req_t;

  typedef struct packed {
    logic [15:0] tick_time;
    logic        running_valid;
    logic [3:0]  running_slot;
    logic [15:0] waiting_mask;
    logic        done_valid;
    logic [15:0] finish_time;
    logic [15:0] turnaround;
    logic [15:0] done_service;
  } tick_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [3:0] cfg_index;
  logic [4:0] cfg_data;

  nts_if #(.payload_t(sched_req_t))   req_ch (.clk(clk));
  nts_if #(.payload_t(tick_result_t)) res_ch (.clk(clk));

  nonpreemptive_tick_scheduler_unit dut (
    .clk(clk), .rst(rst), .in_ch(req_ch.sink), .out_ch(res_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // scheduler shadow state
  logic [15:0] arr_tab [16];
  logic [15:0] svc_tab [16];
  logic [15:0] rem_tab [16];
  logic [3:0]  rq [16];
  logic [3:0]  rq_head, rq_tail;
  int          rq_fill;
  logic [15:0] ready_set;
  logic        cpu_busy;
  logic [3:0]  cur_slot;
  logic [15:0] sim_time;
  logic        pol_mode;
  logic [4:0]  proc_count;

  tick_result_t pending_ticks [$];
  bit  gaps_on;
  int  mismatches, results_seen, reqs_sent, finishes_seen;

  function automatic void load_entry(logic [3:0] idx, logic [15:0] arr, logic [15:0] svc);
    arr_tab[idx] = arr;
    svc_tab[idx] = svc;
    rem_tab[idx] = svc;
  endfunction

  function automatic tick_result_t schedule_tick();
    tick_result_t r;
    int lim;
    int pick;
    logic [3:0] a, b, s;
    logic [15:0] diff;
    logic [16:0] turn;
    lim = (proc_count > 5'd16) ? 16 : int'(proc_count);
    for (int j = 0; j < lim; j++) begin
      if (arr_tab[j] == sim_time && !ready_set[j] && !(cpu_busy && cur_slot == j)) begin
        rem_tab[j] = svc_tab[j];
        ready_set[j] = 1'b1;
        if (rq_fill < 16) begin
          rq[rq_tail] = j[3:0];
          rq_tail = rq_tail + 4'd1;
          rq_fill++;
        end
      end
    end
    if (!cpu_busy && rq_fill > 0) begin
      pick = 0;
      if (pol_mode == POLICY_SPN) begin
        for (int p = 1; p < rq_fill; p++) begin
          a = rq[rq_head + p[3:0]];
          b = rq[rq_head + pick[3:0]];
          if (svc_tab[a] < svc_tab[b]) pick = p;
        end
      end
      s = rq[rq_head + pick[3:0]];
      for (int k = pick; k > 0; k--) rq[rq_head + k[3:0]] = rq[rq_head + k[3:0] - 4'd1];
      rq_head = rq_head + 4'd1;
      rq_fill--;
      cur_slot = s;
      ready_set[s] = 1'b0;
      cpu_busy = 1'b1;
    end
    r = '0;
    r.tick_time = sim_time;
    if (cpu_busy) begin
      rem_tab[cur_slot] = (rem_tab[cur_slot] != 0) ? rem_tab[cur_slot] - 16'd1 : 16'd0;
      r.running_valid = 1'b1;
      r.running_slot = cur_slot;
      if (rem_tab[cur_slot] == 0) begin
        diff = sim_time - arr_tab[cur_slot];
        turn = {1'b0, diff} + 17'd1;
        r.done_valid = 1'b1;
        r.finish_time = sim_time;
        r.turnaround = turn[16] ? 16'hFFFF : turn[15:0];
        r.done_service = svc_tab[cur_slot];
        cpu_busy = 1'b0;
      end
    end
    r.waiting_mask = ready_set;
    sim_time = sim_time + 16'd1;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("nonpreemptive_tick_scheduler_unit regression: fail");
    $finish;
  end

  always @(posedge clk) res_ch.ready <= gaps_on ? ($urandom_range(0, 99) >= 30) : 1'b1;

  // check each accepted result against the oldest expectation
  always @(negedge clk) begin
    tick_result_t exp_r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (pending_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res_ch.data);
      end else begin
        exp_r = pending_ticks.pop_front();
        if (res_ch.data.done_valid) finishes_seen++;
        if (res_ch.data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, res_ch.data);
        end
      end
    end
  end

  task automatic send_req(logic op, logic [3:0] idx, logic [15:0] arr, logic [15:0] svc);
    sched_req_t q;
    bit hs;
    while (gaps_on && $urandom_range(0, 99) < 30) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    q.op = op;
    q.proc_index = idx;
    q.arrival_time = arr;
    q.service_time = svc;
    req_ch.valid <= 1'b1;
    req_ch.data <= q;
    do begin
      @(negedge clk);
      hs = req_ch.ready;
      @(posedge clk);
    end while (!hs);
    reqs_sent++;
    if (op == OP_LOAD) load_entry(idx, arr, svc);
    else pending_ticks = {pending_ticks, schedule_tick()};
  endtask

  task automatic send_tick();
    send_req(OP_TICK, 4'($urandom_range(0, 15)), 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_ticks.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(logic [3:0] idx, logic [4:0] val);
    req_ch.valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_POLICY) pol_mode = val[0];
    else if (idx == CFG_COUNT) proc_count = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_fcfs_basic();
    cfg_write(CFG_COUNT, 5'd16);
    cfg_write(CFG_POLICY, 5'(POLICY_FCFS));
    for (int i = 0; i < 16; i++)
      send_req(OP_LOAD, i[3:0], sim_time + 16'(i / 4 + 1),
               (i == 5) ? 16'd0 : 16'(i % 3 + 1));
    repeat (40) send_tick();
    drain();
  endtask

  task automatic test_spn_all_at_once();
    logic [15:0] t0;
    cfg_write(CFG_POLICY, 5'(POLICY_SPN));
    t0 = sim_time + 16'd18;
    for (int i = 15; i >= 0; i--) send_req(OP_LOAD, i[3:0], t0, 16'((i * 7) % 5 + 1));
    repeat (70) send_tick();
    drain();
  endtask

  task automatic test_config_corners();
    // out-of-range indexes must leave both registers alone
    cfg_write(4'd2, 5'd0);
    cfg_write(4'd15, 5'd31);
    cfg_write(CFG_COUNT, 5'd31);
    send_req(OP_LOAD, 4'd15, sim_time + 16'd3, 16'hFFFF);
    send_req(OP_LOAD, 4'd0, 16'hFFFF, 16'd2);
    send_req(OP_LOAD, 4'd1, sim_time + 16'd2, 16'd3);
    repeat (8) send_tick();
    drain();
    // drop all slots from the scan while slot 15's long job still runs
    cfg_write(CFG_COUNT, 5'd0);
    repeat (6) send_tick();
    drain();
    send_req(OP_LOAD, 4'd15, 16'hFFF0, 16'd1);
  endtask

  task automatic test_random_episodes();
    int n;
    while (reqs_sent < 1850) begin
      cfg_write(CFG_POLICY, 5'($urandom_range(0, 1)));
      cfg_write(CFG_COUNT, ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                                       : 5'($urandom_range(1, 16)));
      for (int i = 0; i < 16; i++) begin
        if ($urandom_range(0, 15) == 0)
          send_req(OP_LOAD, i[3:0], 16'($urandom), 16'($urandom_range(1, 65535)));
        else if ($urandom_range(0, 3) != 0)
          send_req(OP_LOAD, i[3:0], sim_time + 16'($urandom_range(0, 24)),
                   16'($urandom_range(1, 6)));
      end
      n = $urandom_range(20, 45);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_req(OP_LOAD, 4'($urandom_range(0, 15)), sim_time + 16'($urandom_range(0, 10)),
                   16'($urandom_range(1, 8)));
        else
          send_tick();
      end
      drain();
    end
  endtask

  task automatic test_no_gaps();
    // full-rate burst on both sides
    gaps_on = 1'b0;
    cfg_write(CFG_COUNT, 5'd16);
    cfg_write(CFG_POLICY, 5'(POLICY_SPN));
    for (int i = 0; i < 16; i++)
      send_req(OP_LOAD, i[3:0], sim_time + 16'(i % 8), 16'(i % 4 + 1));
    repeat (80) send_tick();
    drain();
    gaps_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;
    gaps_on = 1'b1;
    mismatches = 0;
    results_seen = 0;
    reqs_sent = 0;
    finishes_seen = 0;
    for (int i = 0; i < 16; i++) begin
      arr_tab[i] = '0;
      svc_tab[i] = '0;
      rem_tab[i] = '0;
      rq[i] = '0;
    end
    rq_head = '0;
    rq_tail = '0;
    rq_fill = 0;
    ready_set = '0;
    cpu_busy = 1'b0;
    cur_slot = '0;
    sim_time = '0;
    pol_mode = POLICY_FCFS;
    proc_count = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    repeat (40) send_tick();
    drain();
    test_fcfs_basic();
    test_spn_all_at_once();
    test_config_corners();
    test_random_episodes();
    test_no_gaps();
    drain();
    if (pending_ticks.size() != 0) mismatches++;
    $display("covered %0d requests, %0d tick results, %0d completions", reqs_sent,
             results_seen, finishes_seen);
    $display("both policies, oversize and zero counts, and a gap-free burst exercised");
    if (mismatches == 0) begin
      $display("nonpreemptive_tick_scheduler_unit regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("nonpreemptive_tick_scheduler_unit regression: fail");
    end
    $finish;
  end
endmodule
